[design/lsf_pkg.sv]
// Shared constants and types for the Laplacian sharpen stream filter.
`timescale 1ns / 1ps
`default_nettype none

package lsf_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_CHANNELS = 4;
	localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
	localparam int ADDR_W       = $clog2(LINE_DEPTH);
	localparam int PIX_W        = $clog2(MAX_WIDTH);
	localparam int CHC_W        = $clog2(MAX_CHANNELS);
	localparam int HIST_DEPTH   = 2 * MAX_CHANNELS;

	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 12;
	localparam int CHAN_W   = 3;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;
	localparam logic [CHAN_W-1:0]   CHAN_RST   = 3'd1;

	// per-item position info from the raster tracker
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] ahead_addr;
		logic              row_zero;
		logic              interior;
		logic              last_row;
		logic              last_sample;
	} pos_t;

	// result handed to the output buffer
	typedef struct packed {
		logic [7:0] sample;
		logic       two;
		logic       frame_end;
	} res_t;

endpackage

`default_nettype wire

[design/lsf_ram.sv]
// Simple dual-port line store with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lsf_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/lsf_pos.sv]
// Configuration registers and raster position tracking.
`timescale 1ns / 1ps
`default_nettype none

module lsf_pos
	import lsf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 advance,
	output pos_t                      pos,
	output logic      [CHC_W-1:0]     chan_m1
);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [PIX_W-1:0]    pix_q;
	logic [CHC_W-1:0]    chc_q;
	logic [ADDR_W-1:0]   addr_q;

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [CHAN_W-1:0]   ch_eff;
	logic                last_pix;
	logic                last_chc;
	logic                known_reg;

	always_comb begin
		if (width_q < WIDTH_W'(3)) begin
			w_eff = WIDTH_W'(3);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_q;
		if (chan_q == '0) begin
			ch_eff = CHAN_W'(1);
		end else if (chan_q > CHAN_W'(MAX_CHANNELS)) begin
			ch_eff = CHAN_W'(MAX_CHANNELS);
		end else begin
			ch_eff = chan_q;
		end
	end

	assign chan_m1  = CHC_W'(ch_eff - CHAN_W'(1));
	assign last_pix = ({1'b0, pix_q} == w_eff - WIDTH_W'(1));
	assign last_chc = (chc_q == chan_m1);

	always_comb begin
		pos.addr        = addr_q;
		// neighbour one pixel ahead; past the row end it wraps to the next row's start
		pos.ahead_addr  = last_pix ? ADDR_W'(chc_q) : addr_q + ADDR_W'(ch_eff);
		pos.row_zero    = (row_q == '0);
		pos.interior    = (row_q >= HEIGHT_W'(2)) && (pix_q != '0) && !last_pix;
		pos.last_row    = (row_q == h_eff - HEIGHT_W'(1));
		pos.last_sample = last_pix && last_chc;
	end

	assign known_reg = (cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT) ||
		(cfg_idx == REG_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			chan_q   <= CHAN_RST;
			row_q    <= '0;
			pix_q    <= '0;
			chc_q    <= '0;
			addr_q   <= '0;
		end else if (cfg_we && known_reg) begin
			unique case (cfg_idx)
				REG_WIDTH:  width_q  <= cfg_wdata[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[HEIGHT_W-1:0];
				default:    chan_q   <= cfg_wdata[CHAN_W-1:0];
			endcase
			row_q  <= '0;
			pix_q  <= '0;
			chc_q  <= '0;
			addr_q <= '0;
		end else if (advance) begin
			if (pos.last_sample) begin
				addr_q <= '0;
				pix_q  <= '0;
				chc_q  <= '0;
				row_q  <= pos.last_row ? '0 : row_q + HEIGHT_W'(1);
			end else begin
				addr_q <= addr_q + ADDR_W'(1);
				if (last_chc) begin
					chc_q <= '0;
					pix_q <= pix_q + PIX_W'(1);
				end else begin
					chc_q <= chc_q + CHC_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[design/lsf_out.sv]
// Output register with a pending slot for the zero last-row result.
`timescale 1ns / 1ps
`default_nettype none

module lsf_out
	import lsf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire res_t       res,
	output logic            free,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] sample_out,
	output logic            frame_end
);

	logic valid_q;
	logic pend_q;
	logic pend_fe_q;
	logic [7:0] sample_q;
	logic fe_q;

	assign free       = !pend_q && (!valid_q || out_ready);
	assign out_valid  = valid_q;
	assign sample_out = sample_q;
	assign frame_end  = fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pend_q    <= 1'b0;
			pend_fe_q <= 1'b0;
			sample_q  <= '0;
			fe_q      <= 1'b0;
		end else if (load) begin
			valid_q   <= 1'b1;
			sample_q  <= res.sample;
			fe_q      <= 1'b0;
			pend_q    <= res.two;
			pend_fe_q <= res.frame_end;
		end else if (valid_q && out_ready) begin
			if (pend_q) begin
				sample_q <= '0;
				fe_q     <= pend_fe_q;
				pend_q   <= 1'b0;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[design/laplacian_sharpen_3x3_stream.sv]
// Top level of the streaming 3x3 Laplacian sharpen filter.
`timescale 1ns / 1ps
`default_nettype none

// Five-point sharpen (5*centre minus left, right, upper and lower neighbours of the
// same channel), saturated to 0..255, zero on the frame border. Results trail the
// input by one row: row 0 items give nothing, each middle-row item gives one result,
// each last-row item gives two (the pending row, then a zero of the last row, with
// frame_end on the final one). One item per clock is taken unless the output stalls; in
// the last row the single output register takes no new item until both results are out.
// Items pass stage 1 and the output register. A configuration write restarts the frame.
module laplacian_sharpen_3x3_stream
	import lsf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           sample_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [7:0]           sample_out,
	output logic                      frame_end,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	pos_t             pos;
	logic [CHC_W-1:0] chan_m1;
	logic             accept;
	logic             out_free;
	logic             adv_s1;
	logic             valid_s1;
	pos_t             pos_s1;
	logic [7:0]       x_s1;
	logic [7:0]       right_rd;
	logic [7:0]       up_rd;
	logic [7:0]       hist_q [HIST_DEPTH];
	logic [7:0]       centre;
	logic [7:0]       left;
	logic signed [11:0] acc;
	res_t             res;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign adv_s1    = valid_s1 && (pos_s1.row_zero || out_free);
	assign in_ready  = !valid_s1 || adv_s1;

	lsf_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.advance   (accept),
		.pos       (pos),
		.chan_m1   (chan_m1)
	);

	// previous row, read one pixel ahead of the incoming item
	lsf_ram #(.DEPTH(LINE_DEPTH), .WIDTH(8)) u_middle (
		.clk   (clk),
		.we    (accept),
		.waddr (pos.addr),
		.wdata (sample_in),
		.re    (accept),
		.raddr (pos.ahead_addr),
		.rdata (right_rd)
	);

	// row two back
	lsf_ram #(.DEPTH(LINE_DEPTH), .WIDTH(8)) u_older (
		.clk   (clk),
		.we    (adv_s1 && !pos_s1.row_zero),
		.waddr (pos_s1.addr),
		.wdata (centre),
		.re    (accept),
		.raddr (pos.addr),
		.rdata (up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos;
			x_s1   <= sample_in;
		end
		if (adv_s1) begin
			hist_q[0] <= right_rd;
			for (int k = 1; k < HIST_DEPTH; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	// centre is the look-ahead read one pixel back, left two pixels back
	always_comb begin
		case (chan_m1)
			2'd0:    begin centre = hist_q[0]; left = hist_q[1]; end
			2'd1:    begin centre = hist_q[1]; left = hist_q[3]; end
			2'd2:    begin centre = hist_q[2]; left = hist_q[5]; end
			default: begin centre = hist_q[3]; left = hist_q[7]; end
		endcase
	end

	always_comb begin
		acc = 12'sd5 * $signed({4'd0, centre})
			- $signed({4'd0, left}) - $signed({4'd0, right_rd})
			- $signed({4'd0, up_rd}) - $signed({4'd0, x_s1});
		res.sample = 8'd0;
		if (pos_s1.interior) begin
			if (acc < 12'sd0) begin
				res.sample = 8'd0;
			end else if (acc > 12'sd255) begin
				res.sample = 8'd255;
			end else begin
				res.sample = acc[7:0];
			end
		end
		res.two       = pos_s1.last_row;
		res.frame_end = pos_s1.last_row && pos_s1.last_sample;
	end

	lsf_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv_s1 && !pos_s1.row_zero),
		.res        (res),
		.free       (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.frame_end  (frame_end)
	);

endmodule

`default_nettype wire
